@@ hw/rtl/dpic_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpic_pkg
// Shared types and constants of the dual-port parallel I/O interrupt controller.
// ----------------------------------------------------------------------------
package dpic_pkg;

  localparam int NUM_PORTS = 2;
  localparam int BYTE_W    = 8;

  typedef enum logic [1:0] {
    KIND_CTRL = 2'd0,
    KIND_DATA = 2'd1,
    KIND_POLL = 2'd2,
    KIND_RETI = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    SVC_NONE = 2'd0,
    SVC_A    = 2'd1,
    SVC_B    = 2'd2
  } svc_t;

  // Control word low-nibble codes
  localparam logic [3:0] CW_MODE   = 4'hf;
  localparam logic [3:0] CW_INTCTL = 4'h7;
  localparam logic [3:0] CW_ENABLE = 4'h3;

  localparam logic [1:0] MODE_RESET = 2'd1;
  localparam logic [1:0] MODE_BIDIR = 2'd3;

endpackage

@@ hw/rtl/dpic_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpic_in_if / dpic_out_if
// Valid/ready channels for bus items into the controller and results out.
// ----------------------------------------------------------------------------
interface dpic_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic       port;
  logic [7:0] value;
  logic [7:0] bit_mask;

  modport source (output valid, kind, port, value, bit_mask, input ready);
  modport sink   (input valid, kind, port, value, bit_mask, output ready);
endinterface

interface dpic_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_a;
  logic [7:0] data_b;
  logic       int_claimed;
  logic [7:0] int_vector;
  logic [1:0] service_port;

  modport source (output valid, data_a, data_b, int_claimed, int_vector, service_port,
                  input ready);
  modport sink   (input valid, data_a, data_b, int_claimed, int_vector, service_port,
                  output ready);
endinterface

@@ hw/rtl/dual_port_pio_interrupt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_port_pio_interrupt_ctrl
// Two-port parallel I/O controller with bit-pattern interrupt matching.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one bus item per transfer: a control write, a data write,
//   an interrupt poll or a return from interrupt, aimed at port A or B.
//   out_ch returns exactly one result per item: both data bytes, the claim
//   flag, the vector of the port in service and the service code.
// Result: the result of an item is registered and is valid on out_ch in
//   the cycle after its transfer on in_ch.
// Throughput: one item per cycle while out_ch is not held. The port
//   registers are updated in the cycle of the transfer, so the next item
//   sees them at once; the single result register sets the rate.
// Reset: all port registers take their power-up values (mode 1, interrupts
//   off, nothing in service) and out_ch goes empty.
// Stall: while out_ch is held, the result register keeps its value and
//   in_ch.ready drops; a new item is taken in the same cycle the held
//   result transfers.
// ----------------------------------------------------------------------------
module dual_port_pio_interrupt_ctrl
  import dpic_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  dpic_in_if.sink            in_ch,
  dpic_out_if.source         out_ch
);

  // Port state
  logic [7:0] data_r      [NUM_PORTS];
  logic [7:0] data_nxt    [NUM_PORTS];
  logic [7:0] mmask_r     [NUM_PORTS];
  logic [7:0] mmask_nxt   [NUM_PORTS];
  logic [1:0] mode_r      [NUM_PORTS];
  logic [1:0] mode_nxt    [NUM_PORTS];
  logic [7:0] dir_r       [NUM_PORTS];
  logic [7:0] dir_nxt     [NUM_PORTS];
  logic [7:0] vec_r       [NUM_PORTS];
  logic [7:0] vec_nxt     [NUM_PORTS];
  logic       ien_r       [NUM_PORTS];
  logic       ien_nxt     [NUM_PORTS];
  logic       andm_r      [NUM_PORTS];
  logic       andm_nxt    [NUM_PORTS];
  logic       ahigh_r     [NUM_PORTS];
  logic       ahigh_nxt   [NUM_PORTS];
  logic       exp_dir_r   [NUM_PORTS];
  logic       exp_dir_nxt [NUM_PORTS];
  logic       exp_msk_r   [NUM_PORTS];
  logic       exp_msk_nxt [NUM_PORTS];
  logic       match       [NUM_PORTS];
  svc_t       svc_r;
  svc_t       svc_nxt;
  logic       claimed;
  logic [7:0] vec_out;

  // Result register
  logic       out_valid_r;
  logic [7:0] out_data_a_r;
  logic [7:0] out_data_b_r;
  logic       out_claimed_r;
  logic [7:0] out_vector_r;
  logic [1:0] out_svc_r;

  logic       accept;
  kind_t      kind;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign kind        = kind_t'(in_ch.kind);

  always_comb begin
    logic [7:0] dt;
    logic       hit;
    logic       serviced;
    for (int i = 0; i < NUM_PORTS; i++) begin
      dt = ahigh_r[i] ? data_r[i] : ~data_r[i];
      dt = dt & mmask_r[i];
      if (!ien_r[i]) begin
        match[i] = 1'b0;
      end else if (andm_r[i]) begin
        match[i] = (dt == mmask_r[i]);
      end else begin
        match[i] = (dt != 8'h00);
      end
    end

    // Poll: port B has priority
    svc_nxt = svc_r;
    claimed = 1'b0;
    if (kind == KIND_POLL && svc_r == SVC_NONE) begin
      if (match[1]) begin
        svc_nxt = SVC_B;
        claimed = 1'b1;
      end else if (match[0]) begin
        svc_nxt = SVC_A;
        claimed = 1'b1;
      end
    end else if (kind == KIND_RETI && svc_r != SVC_NONE) begin
      svc_nxt = SVC_NONE;
    end

    for (int i = 0; i < NUM_PORTS; i++) begin
      data_nxt[i]    = data_r[i];
      mmask_nxt[i]   = mmask_r[i];
      mode_nxt[i]    = mode_r[i];
      dir_nxt[i]     = dir_r[i];
      vec_nxt[i]     = vec_r[i];
      ien_nxt[i]     = ien_r[i];
      andm_nxt[i]    = andm_r[i];
      ahigh_nxt[i]   = ahigh_r[i];
      exp_dir_nxt[i] = exp_dir_r[i];
      exp_msk_nxt[i] = exp_msk_r[i];
      hit            = (in_ch.port == 1'(i));
      serviced       = (i == 0) ? (svc_r == SVC_A) : (svc_r == SVC_B);

      case (kind)
        KIND_CTRL: begin
          if (hit) begin
            if (exp_dir_r[i]) begin
              exp_dir_nxt[i] = 1'b0;
              dir_nxt[i]     = in_ch.value;
            end else if (exp_msk_r[i]) begin
              exp_msk_nxt[i] = 1'b0;
              mmask_nxt[i]   = ~in_ch.value;
            end else if (!in_ch.value[0]) begin
              vec_nxt[i] = in_ch.value;
            end else if (in_ch.value[3:0] == CW_MODE) begin
              mode_nxt[i]    = in_ch.value[7:6];
              exp_dir_nxt[i] = (in_ch.value[7:6] == MODE_BIDIR);
            end else if (in_ch.value[3:0] == CW_INTCTL) begin
              ien_nxt[i]     = in_ch.value[7];
              andm_nxt[i]    = in_ch.value[6];
              ahigh_nxt[i]   = in_ch.value[5];
              exp_msk_nxt[i] = in_ch.value[4];
            end else if (in_ch.value[3:0] == CW_ENABLE) begin
              ien_nxt[i] = in_ch.value[7];
            end
          end
        end
        KIND_DATA: begin
          if (hit) begin
            data_nxt[i] = (data_r[i] & ~in_ch.bit_mask) | (in_ch.value & in_ch.bit_mask);
          end
        end
        KIND_RETI: begin
          // Drive matched bits back to their idle level
          if (serviced) begin
            data_nxt[i] = ahigh_r[i] ? (data_r[i] & ~mmask_r[i]) : (data_r[i] | mmask_r[i]);
          end
        end
        default: begin
        end
      endcase
    end

    case (svc_nxt)
      SVC_A:   vec_out = vec_nxt[0];
      SVC_B:   vec_out = vec_nxt[1];
      default: vec_out = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        data_r[i]    <= '0;
        mmask_r[i]   <= '0;
        mode_r[i]    <= MODE_RESET;
        dir_r[i]     <= '0;
        vec_r[i]     <= '0;
        ien_r[i]     <= 1'b0;
        andm_r[i]    <= 1'b0;
        ahigh_r[i]   <= 1'b0;
        exp_dir_r[i] <= 1'b0;
        exp_msk_r[i] <= 1'b0;
      end
      svc_r       <= SVC_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        for (int i = 0; i < NUM_PORTS; i++) begin
          data_r[i]    <= data_nxt[i];
          mmask_r[i]   <= mmask_nxt[i];
          mode_r[i]    <= mode_nxt[i];
          dir_r[i]     <= dir_nxt[i];
          vec_r[i]     <= vec_nxt[i];
          ien_r[i]     <= ien_nxt[i];
          andm_r[i]    <= andm_nxt[i];
          ahigh_r[i]   <= ahigh_nxt[i];
          exp_dir_r[i] <= exp_dir_nxt[i];
          exp_msk_r[i] <= exp_msk_nxt[i];
        end
        svc_r       <= svc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: load on transfer, hold otherwise
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_a_r  <= data_nxt[0];
      out_data_b_r  <= data_nxt[1];
      out_claimed_r <= claimed;
      out_vector_r  <= vec_out;
      out_svc_r     <= svc_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.data_a       = out_data_a_r;
  assign out_ch.data_b       = out_data_b_r;
  assign out_ch.int_claimed  = out_claimed_r;
  assign out_ch.int_vector   = out_vector_r;
  assign out_ch.service_port = out_svc_r;

  // Mode and direction are kept for readback-free bookkeeping only
  logic unused_cfg;
  assign unused_cfg = ^{mode_r[0], mode_r[1], dir_r[0], dir_r[1]};

endmodule

@@ hw/rtl/dpic_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpic_checker
// Port-level checks of the interrupt controller, bound to the top level.
// ----------------------------------------------------------------------------
module dpic_checker
  import dpic_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_int_claimed,
  input logic [7:0] out_int_vector,
  input logic [1:0] out_service_port
);

  // A held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Every transfer in yields a result next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  a_claim_svc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_int_claimed |-> out_service_port != SVC_NONE)
    else $error("claim without a port in service");

  a_svc_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_service_port != 2'd3)
    else $error("illegal service code");

  a_vec_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_service_port == SVC_NONE |-> out_int_vector == 8'h00)
    else $error("vector shown with none in service");

endmodule

bind dual_port_pio_interrupt_ctrl dpic_checker u_dpic_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_int_claimed  (out_ch.int_claimed),
  .out_int_vector   (out_ch.int_vector),
  .out_service_port (out_ch.service_port)
);
